/* rtl/lirs_pkg.sv */
`default_nettype none

package lirs_pkg;

	localparam int SAMPLE_BITS_DEF   = 24;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int STEP_W  = 21;
	localparam int COUNT_W = 23;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [STEP_W-1:0]  STEP_RESET  = 21'd65536;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = 23'd960000;

	typedef enum logic {
		REG_PHASE_STEP = 1'b0,
		REG_MAX_OUTPUT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_PUT,
		S_WRAP
	} state_t;

	typedef struct packed {
		logic load_in;
		logic load_first;
		logic clear_run;
		logic mul;
		logic put_real;
		logic put_over;
		logic put_end;
		logic wrap;
	} dp_cmd_t;

	typedef struct packed {
		logic stopped;
		logic have_prev;
		logic last;
		logic pos_lt_one;
		logic pos_lt_two;
		logic nxt_lt_one;
		logic nxt_lt_two;
		logic limit_hit;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

/* rtl/lirs_regs.sv */
`default_nettype none

module lirs_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lirs_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [lirs_pkg::DATA_W-1:0]  pwdata,
	output logic      [lirs_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	output logic      [lirs_pkg::STEP_W-1:0]  phase_step,
	output logic      [lirs_pkg::COUNT_W-1:0] max_output_count
);
	import lirs_pkg::*;

	reg_idx_t             idx;
	logic                 wr_en;
	logic [STEP_W-1:0]    step_q;
	logic [COUNT_W-1:0]   limit_q;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_RESET;
			limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_PHASE_STEP: step_q  <= pwdata[STEP_W-1:0];
				REG_MAX_OUTPUT: limit_q <= pwdata[COUNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PHASE_STEP: prdata = DATA_W'(step_q);
			REG_MAX_OUTPUT: prdata = DATA_W'(limit_q);
		endcase
	end

	assign phase_step       = step_q;
	assign max_output_count = limit_q;

endmodule

`default_nettype wire

/* rtl/lirs_ctrl.sv */
`default_nettype none

module lirs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               is_last,
	output logic                    in_stall,
	input  wire lirs_pkg::dp_stat_t stat,
	output lirs_pkg::dp_cmd_t       cmd
);
	import lirs_pkg::*;

	state_t state_q, state_d;
	logic   tail_q, tail_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tail_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			tail_q  <= tail_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		tail_d   = tail_q;
		cmd      = '0;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (stat.stopped) begin
						cmd.clear_run = is_last;
					end else if (!stat.have_prev) begin
						cmd.load_first = 1'b1;
						if (is_last) begin
							tail_d  = 1'b1;
							state_d = S_MUL;
						end
					end else if (stat.pos_lt_one) begin
						state_d = S_MUL;
					end else begin
						state_d = S_WRAP;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_PUT;
			end
			S_PUT: begin
				if (stat.out_free) begin
					if (stat.limit_hit) begin
						// limit reached: over-limit beat ends the run
						cmd.put_over  = 1'b1;
						cmd.clear_run = stat.last;
						tail_d        = 1'b0;
						state_d       = S_IDLE;
					end else begin
						cmd.put_real = 1'b1;
						cmd.put_end  = stat.last &&
							(tail_q ? !stat.nxt_lt_one : !stat.nxt_lt_two);
						if (stat.nxt_lt_one) begin
							state_d = S_MUL;
						end else if (tail_q) begin
							cmd.clear_run = 1'b1;
							tail_d        = 1'b0;
							state_d       = S_IDLE;
						end else begin
							state_d = S_WRAP;
						end
					end
				end
			end
			S_WRAP: begin
				cmd.wrap = 1'b1;
				if (stat.last && stat.pos_lt_two) begin
					tail_d  = 1'b1;
					state_d = S_MUL;
				end else begin
					cmd.clear_run = stat.last;
					state_d       = S_IDLE;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/lirs_dp.sv */
`default_nettype none

module lirs_dp #(
	parameter int SAMPLE_BITS   = lirs_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = lirs_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample,
	input  wire logic                              is_last,
	input  wire logic [lirs_pkg::STEP_W-1:0]       phase_step,
	input  wire logic [lirs_pkg::COUNT_W-1:0]      max_output_count,
	input  wire lirs_pkg::dp_cmd_t                 cmd,
	output lirs_pkg::dp_stat_t                     stat,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [SAMPLE_BITS-1:0]          out_sample,
	output logic                                   end_of_run,
	output logic                                   over_limit
);
	import lirs_pkg::*;

	localparam int POS_W  = FRACTION_BITS + 5;
	localparam int CMP_W  = (POS_W > STEP_W) ? POS_W : STEP_W;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int SUM_W  = SAMPLE_BITS + 2;
	localparam int PROD_W = SAMPLE_BITS + FRACTION_BITS + 2;

	localparam logic [POS_W-1:0]         ONE_POS  = POS_W'(1) << FRACTION_BITS;
	localparam logic [POS_W-1:0]         TWO_POS  = POS_W'(2) << FRACTION_BITS;
	localparam logic [CMP_W-1:0]         MIN_STEP = CMP_W'(1) << (FRACTION_BITS - 5);
	localparam logic [CMP_W-1:0]         MAX_STEP = CMP_W'(1) << (FRACTION_BITS + 4);
	localparam logic signed [PROD_W-1:0] HALF     = PROD_W'(1) << (FRACTION_BITS - 1);

	logic signed [SAMPLE_BITS-1:0] prev_q, cur_q;
	logic [POS_W-1:0]              pos_q;
	logic                          have_q, stopped_q, last_q;
	logic [COUNT_W-1:0]            count_q;
	logic signed [PROD_W-1:0]      prod_s1;
	logic                          out_valid_q, end_q, over_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;

	logic [CMP_W-1:0]              step_ext, step_sat;
	logic [POS_W-1:0]              step_use, nxt_pos;
	logic signed [DIFF_W-1:0]      diff;
	logic signed [FRACTION_BITS:0] frac;
	logic signed [PROD_W-1:0]      prod_full;
	logic signed [SUM_W-1:0]       quot, result;
	logic                          out_free;

	// step clamped to [1/32, 16] source samples
	assign step_ext = CMP_W'(phase_step);
	always_comb begin
		if (step_ext < MIN_STEP) begin
			step_sat = MIN_STEP;
		end else if (step_ext > MAX_STEP) begin
			step_sat = MAX_STEP;
		end else begin
			step_sat = step_ext;
		end
	end
	assign step_use = step_sat[POS_W-1:0];
	assign nxt_pos  = pos_q + step_use;

	assign diff      = {cur_q[SAMPLE_BITS-1], cur_q} - {prev_q[SAMPLE_BITS-1], prev_q};
	assign frac      = $signed({1'b0, pos_q[FRACTION_BITS-1:0]});
	assign prod_full = diff * frac;

	// floor of the rounded product, then add to the previous sample
	assign quot   = $signed(prod_s1[PROD_W-1:FRACTION_BITS]);
	assign result = {{2{prev_q[SAMPLE_BITS-1]}}, prev_q} + quot;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			pos_q     <= '0;
			have_q    <= 1'b0;
			stopped_q <= 1'b0;
			count_q   <= '0;
			last_q    <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				last_q <= is_last;
			end
			if (cmd.clear_run) begin
				prev_q    <= '0;
				pos_q     <= '0;
				have_q    <= 1'b0;
				stopped_q <= 1'b0;
				count_q   <= '0;
			end else begin
				if (cmd.load_first) begin
					prev_q <= sample;
					have_q <= 1'b1;
					pos_q  <= '0;
				end
				if (cmd.put_real) begin
					count_q <= count_q + COUNT_W'(1);
					pos_q   <= nxt_pos;
				end
				if (cmd.put_over) begin
					stopped_q <= 1'b1;
				end
				if (cmd.wrap) begin
					pos_q  <= pos_q - ONE_POS;
					prev_q <= cur_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_q <= sample;
		end
		if (cmd.mul) begin
			prod_s1 <= prod_full + HALF;
		end
		if (cmd.put_real || cmd.put_over) begin
			out_sample_q <= cmd.put_over ? '0 : result[SAMPLE_BITS-1:0];
			end_q        <= cmd.put_over || cmd.put_end;
			over_q       <= cmd.put_over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put_real || cmd.put_over) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.stopped    = stopped_q;
		stat.have_prev  = have_q;
		stat.last       = last_q;
		stat.pos_lt_one = pos_q < ONE_POS;
		stat.pos_lt_two = pos_q < TWO_POS;
		stat.nxt_lt_one = nxt_pos < ONE_POS;
		stat.nxt_lt_two = nxt_pos < TWO_POS;
		stat.limit_hit  = count_q >= max_output_count;
		stat.out_free   = out_free;
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign end_of_run = end_q;
	assign over_limit = over_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.put_real || cmd.put_over) |-> (!out_valid_q || !out_stall))
		else $error("output beat overwritten while held");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> (pos_q < ONE_POS))
		else $error("interpolation position outside current sample");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.put_real, cmd.put_over, cmd.wrap, cmd.load_first}))
		else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

/* rtl/linear_interp_resampler_top.sv */
// flow: an item is accepted in S_IDLE; each output beat goes through S_MUL, which
//   registers the product of the one multiplier, then S_PUT, which registers the beat
// S_WRAP moves the position into the next sample; in_stall holds off a new item until
//   the controller is back in S_IDLE; output stall holds the product in place
// reset: arst_n clears run state and output valid; phase_step and max_output_count
//   return to 65536 and 960000
`default_nettype none

module linear_interp_resampler_top #(
	parameter int SAMPLE_BITS   = lirs_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = lirs_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]    sample,
	input  wire logic                             is_last,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [SAMPLE_BITS-1:0]         out_sample,
	output logic                                  end_of_run,
	output logic                                  over_limit,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [lirs_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [lirs_pkg::DATA_W-1:0]      pwdata,
	output logic      [lirs_pkg::DATA_W-1:0]      prdata,
	output logic                                  pready
);
	import lirs_pkg::*;

	logic [STEP_W-1:0]  phase_step;
	logic [COUNT_W-1:0] max_output_count;
	dp_cmd_t            cmd;
	dp_stat_t           stat;

	lirs_regs u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.phase_step       (phase_step),
		.max_output_count (max_output_count)
	);

	lirs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.is_last  (is_last),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lirs_dp #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample           (sample),
		.is_last          (is_last),
		.phase_step       (phase_step),
		.max_output_count (max_output_count),
		.cmd              (cmd),
		.stat             (stat),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_sample       (out_sample),
		.end_of_run       (end_of_run),
		.over_limit       (over_limit)
	);

endmodule

`default_nettype wire
